// ===== rtl/thsh_pkg.sv =====
// Shared types and constants for the terrain height snap block.
// No dependencies; imported by thsh_ctrl, thsh_datapath and the top level.
package thsh_pkg;

    localparam int CW  = 16;  // coordinate width, Q7.8
    localparam int EW  = 17;  // edge / offset component width
    localparam int DW  = 28;  // truncated dot product width
    localparam int AW  = 36;  // dot product accumulator width
    localparam int PW  = 56;  // den / vn / wn width
    localparam int FW  = 16;  // barycentric fraction width
    localparam int SW  = 35;  // height accumulator width
    localparam int RW  = 9;   // triangle count register width

    typedef enum logic [1:0] {
        MODE_VERTEX   = 2'd0,
        MODE_TRIANGLE = 2'd1,
        MODE_QUERY    = 2'd2,
        MODE_NONE     = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_TRI_COUNT   = 2'd0,
        REG_SNAP_OFFSET = 2'd1,
        REG_LOWER_THR   = 2'd2,
        REG_UPPER_THR   = 2'd3
    } t_reg;

    typedef enum logic [4:0] {
        S_IDLE, S_SCAN, S_RD_TRI, S_CHK, S_RD_B, S_RD_C, S_EDGE, S_DOT,
        S_MUL, S_TEST, S_DIV, S_HGT1, S_HGT2, S_HGT3, S_NEXT, S_FINISH
    } t_state;

    typedef enum logic [3:0] {
        OP_NOP, OP_QSTART, OP_TRI_RD, OP_RD_A, OP_RD_B, OP_RD_C, OP_EDGE,
        OP_DOT, OP_MUL, OP_DIV_INIT, OP_DIV, OP_H1, OP_H2, OP_H3,
        OP_TRI_INC, OP_FINISH
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [2:0] dot_sel;
        logic [1:0] comp_sel;
        logic [3:0] step;
    } t_cmd;

    typedef struct packed {
        logic scan_end;
        logic bad_corner;
        logic reject;
    } t_stat;

endpackage

// ===== rtl/thsh_ctrl.sv =====
// Query sequencer: steps one triangle at a time through read, dot, multiply,
// test, divide and interpolate. Depends on thsh_pkg.
module thsh_ctrl
    import thsh_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_query_go,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic [2:0] r_dot, n_dot;
    logic [1:0] r_comp, n_comp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_dot   <= '0;
            r_comp  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_dot   <= n_dot;
            r_comp  <= n_comp;
        end
    end

    // step counters
    always_comb begin
        n_cnt  = 4'd0;
        n_dot  = 3'd0;
        n_comp = 2'd0;
        case (r_state)
            S_DOT: begin
                if (r_comp == 2'd2) begin
                    n_dot = r_dot + 3'd1;
                end else begin
                    n_dot  = r_dot;
                    n_comp = r_comp + 2'd1;
                end
            end
            S_MUL, S_DIV: begin
                n_cnt = r_cnt + 4'd1;
            end
            default: begin
                n_cnt = 4'd0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_query_go) n_state = S_SCAN;
            S_SCAN:   n_state = i_stat.scan_end ? S_FINISH : S_RD_TRI;
            S_RD_TRI: n_state = S_CHK;
            S_CHK:    n_state = i_stat.bad_corner ? S_NEXT : S_RD_B;
            S_RD_B:   n_state = S_RD_C;
            S_RD_C:   n_state = S_EDGE;
            S_EDGE:   n_state = S_DOT;
            S_DOT:    if (r_dot == 3'd4 && r_comp == 2'd2) n_state = S_MUL;
            S_MUL:    if (r_cnt == 4'd11) n_state = S_TEST;
            S_TEST:   n_state = i_stat.reject ? S_NEXT : S_DIV;
            S_DIV:    if (r_cnt == 4'd15) n_state = S_HGT1;
            S_HGT1:   n_state = S_HGT2;
            S_HGT2:   n_state = S_HGT3;
            S_HGT3:   n_state = S_FINISH;
            S_NEXT:   n_state = S_SCAN;
            S_FINISH: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd.op       = OP_NOP;
        o_cmd.dot_sel  = r_dot;
        o_cmd.comp_sel = r_comp;
        o_cmd.step     = r_cnt;
        case (r_state)
            S_IDLE:   o_cmd.op = i_query_go ? OP_QSTART : OP_NOP;
            S_RD_TRI: o_cmd.op = OP_TRI_RD;
            S_CHK:    o_cmd.op = OP_RD_A;
            S_RD_B:   o_cmd.op = OP_RD_B;
            S_RD_C:   o_cmd.op = OP_RD_C;
            S_EDGE:   o_cmd.op = OP_EDGE;
            S_DOT:    o_cmd.op = OP_DOT;
            S_MUL:    o_cmd.op = OP_MUL;
            S_TEST:   o_cmd.op = OP_DIV_INIT;
            S_DIV:    o_cmd.op = OP_DIV;
            S_HGT1:   o_cmd.op = OP_H1;
            S_HGT2:   o_cmd.op = OP_H2;
            S_HGT3:   o_cmd.op = OP_H3;
            S_NEXT:   o_cmd.op = OP_TRI_INC;
            S_FINISH: o_cmd.op = OP_FINISH;
            default:  o_cmd.op = OP_NOP;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/thsh_datapath.sv =====
// Stores, arithmetic and result registers of the terrain height snap block.
// Depends on thsh_pkg; driven by thsh_ctrl commands.
module thsh_datapath
    import thsh_pkg::*;
#(
    parameter int MAX_VERTICES  = 128,
    parameter int MAX_TRIANGLES = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [1:0]            i_mode,
    input  logic [7:0]            i_slot,
    input  logic signed [CW-1:0]  i_coord_x,
    input  logic signed [CW-1:0]  i_coord_y,
    input  logic signed [CW-1:0]  i_coord_z,
    input  logic [6:0]            i_corner_a,
    input  logic [6:0]            i_corner_b,
    input  logic [6:0]            i_corner_c,
    input  logic [RW-1:0]         i_tri_count,
    input  logic signed [CW-1:0]  i_snap_offset,
    input  logic signed [CW-1:0]  i_lower_thr,
    input  logic signed [CW-1:0]  i_upper_thr,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    output logic                  o_valid,
    output logic signed [CW-1:0]  o_new_z,
    output logic signed [CW-1:0]  o_terrain_height,
    output logic                  o_triangle_found,
    output logic                  o_above_flag
);

    localparam int VAW = (MAX_VERTICES  > 1) ? $clog2(MAX_VERTICES)  : 1;
    localparam int TAW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int TIW = $clog2(MAX_TRIANGLES + 1);

    logic [3*CW-1:0] r_vmem [MAX_VERTICES];
    logic [20:0]     r_tmem [MAX_TRIANGLES];

    logic [3*CW-1:0] r_vrd, r_va, r_vb;
    logic [20:0]     r_tri;
    logic [TIW-1:0]  r_tri_idx;
    logic [VAW-1:0]  vaddr;

    logic signed [CW-1:0] r_px, r_py, r_pz;
    logic signed [EW-1:0] r_e1x, r_e1y, r_e1z, r_e2x, r_e2y, r_e2z, r_qx, r_qy, r_qz;
    logic signed [DW-1:0] r_d00, r_d01, r_d11, r_d20, r_d21;
    logic signed [AW-1:0] r_dacc;
    logic signed [PW-1:0] r_macc, r_den, r_vn, r_wn;
    logic [PW-1:0]        r_rv, r_rw;
    logic [FW-1:0]        r_fv, r_fw;
    logic signed [SW-1:0] r_hacc;
    logic signed [CW-1:0] r_height;
    logic                 r_found, r_flag, r_valid;
    logic signed [CW-1:0] r_out_z, r_out_h;
    logic                 r_out_f;

    function automatic logic signed [EW-1:0] sub_e(input logic [CW-1:0] a,
                                                   input logic [CW-1:0] b);
        return EW'($signed(a)) - EW'($signed(b));
    endfunction

    // loads and store reads
    always_comb begin
        case (i_cmd.op)
            OP_RD_B: vaddr = VAW'(r_tri[13:7]);
            OP_RD_C: vaddr = VAW'(r_tri[20:14]);
            default: vaddr = VAW'(r_tri[6:0]);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_mode == MODE_VERTEX && 32'(i_slot) < 32'(MAX_VERTICES)) begin
            r_vmem[VAW'(i_slot)] <= {i_coord_z, i_coord_y, i_coord_x};
        end
        r_vrd <= r_vmem[vaddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && i_mode == MODE_TRIANGLE && 32'(i_slot) < 32'(MAX_TRIANGLES)) begin
            r_tmem[TAW'(i_slot)] <= {i_corner_c, i_corner_b, i_corner_a};
        end
        if (i_cmd.op == OP_TRI_RD) begin
            r_tri <= r_tmem[TAW'(r_tri_idx)];
        end
    end

    // dot products, one component product a cycle
    logic signed [EW-1:0]   e1c, e2c, qc, dl, dr;
    logic signed [2*EW-1:0] dprod;
    logic signed [AW-1:0]   dsum, dbias;
    logic signed [DW-1:0]   dq;

    always_comb begin
        case (i_cmd.comp_sel)
            2'd0:    begin e1c = r_e1x; e2c = r_e2x; qc = r_qx; end
            2'd1:    begin e1c = r_e1y; e2c = r_e2y; qc = r_qy; end
            default: begin e1c = r_e1z; e2c = r_e2z; qc = r_qz; end
        endcase
        case (i_cmd.dot_sel)
            3'd0, 3'd1: dl = e1c;
            3'd2:       dl = e2c;
            default:    dl = qc;
        endcase
        case (i_cmd.dot_sel)
            3'd0, 3'd3: dr = e1c;
            default:    dr = e2c;
        endcase
        dprod = dl * dr;
        dsum  = ((i_cmd.comp_sel == 2'd0) ? AW'(0) : r_dacc) + AW'(dprod);
        dbias = dsum + (dsum[AW-1] ? AW'(255) : AW'(0));
        dq    = DW'(dbias >>> 8);
    end

    // den / vn / wn: each 28x28 product as two partial products
    logic [2:0]           mp;
    logic                 mhalf;
    logic signed [DW-1:0] ma, mb;
    logic signed [DW+14:0] mlo;
    logic signed [DW+13:0] mhi;
    logic signed [PW-1:0] mterm, mbase, msum;

    always_comb begin
        mp    = i_cmd.step[3:1];
        mhalf = i_cmd.step[0];
        case (mp)
            3'd0:    begin ma = r_d00; mb = r_d11; end
            3'd1:    begin ma = r_d01; mb = r_d01; end
            3'd2:    begin ma = r_d11; mb = r_d20; end
            3'd3:    begin ma = r_d01; mb = r_d21; end
            3'd4:    begin ma = r_d00; mb = r_d21; end
            default: begin ma = r_d01; mb = r_d20; end
        endcase
        mlo   = ma * $signed({1'b0, mb[13:0]});
        mhi   = ma * $signed(mb[DW-1:14]);
        mterm = mhalf ? (PW'(mhi) <<< 14) : PW'(mlo);
        mbase = (!mp[0] && !mhalf) ? PW'(0) : r_macc;
        msum  = mp[0] ? (mbase - mterm) : (mbase + mterm);
    end

    // inside test
    logic signed [PW:0] vw_sum;
    assign vw_sum = (PW+1)'(r_vn) + (PW+1)'(r_wn);
    assign o_stat.reject = (r_den <= 0) || r_vn[PW-1] || r_wn[PW-1] ||
                           (vw_sum >= (PW+1)'(r_den));
    assign o_stat.bad_corner = (32'(r_tri[6:0])   >= 32'(MAX_VERTICES)) ||
                               (32'(r_tri[13:7])  >= 32'(MAX_VERTICES)) ||
                               (32'(r_tri[20:14]) >= 32'(MAX_VERTICES));

    logic [31:0] scan_n;
    assign scan_n = (32'(i_tri_count) > 32'(MAX_TRIANGLES)) ? 32'(MAX_TRIANGLES)
                                                            : 32'(i_tri_count);
    assign o_stat.scan_end = (32'(r_tri_idx) >= scan_n);

    // restoring division, one quotient bit a cycle for both fractions
    logic [PW:0] rv2, rw2, dden;
    logic        gev, gew;
    assign rv2  = {r_rv, 1'b0};
    assign rw2  = {r_rw, 1'b0};
    assign dden = {1'b0, r_den};
    assign gev  = (rv2 >= dden);
    assign gew  = (rw2 >= dden);

    // interpolation and snap
    logic signed [2*EW-1:0] hprod;
    logic signed [SW-1:0]   hbias;
    logic signed [19:0]     hsum;
    logic signed [CW-1:0]   hsat;
    logic signed [CW:0]     lim, snap;
    logic signed [CW-1:0]   snap_sat, thr;
    logic                   do_snap;

    always_comb begin
        hprod = (i_cmd.op == OP_H1) ? $signed({1'b0, r_fv}) * r_e1y
                                    : $signed({1'b0, r_fw}) * r_e2y;
        hbias = r_hacc + (r_hacc[SW-1] ? SW'(65535) : SW'(0));
        hsum  = 20'($signed(r_va[2*CW-1:CW])) + 20'(hbias >>> 16);
        if (hsum > 20'sd32767)       hsat = 16'sh7FFF;
        else if (hsum < -20'sd32768) hsat = 16'sh8000;
        else                         hsat = CW'(hsum);
        thr     = r_flag ? i_lower_thr : i_upper_thr;
        lim     = (CW+1)'(r_height) + (CW+1)'(thr);
        do_snap = ((CW+1)'(r_pz) < lim);
        snap    = (CW+1)'(r_height) + (CW+1)'(i_snap_offset);
        if (snap > 17'sd32767)       snap_sat = 16'sh7FFF;
        else if (snap < -17'sd32768) snap_sat = 16'sh8000;
        else                         snap_sat = CW'(snap);
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_QSTART: begin
                r_px      <= i_coord_x;
                r_py      <= i_coord_y;
                r_pz      <= i_coord_z;
                r_tri_idx <= '0;
                r_height  <= '0;
                r_found   <= 1'b0;
            end
            OP_RD_B: r_va <= r_vrd;
            OP_RD_C: r_vb <= r_vrd;
            OP_EDGE: begin
                r_e1x <= sub_e(r_vb[CW-1:0],      r_va[CW-1:0]);
                r_e1y <= sub_e(r_vb[2*CW-1:CW],   r_va[2*CW-1:CW]);
                r_e1z <= sub_e(r_vb[3*CW-1:2*CW], r_va[3*CW-1:2*CW]);
                r_e2x <= sub_e(r_vrd[CW-1:0],      r_va[CW-1:0]);
                r_e2y <= sub_e(r_vrd[2*CW-1:CW],   r_va[2*CW-1:CW]);
                r_e2z <= sub_e(r_vrd[3*CW-1:2*CW], r_va[3*CW-1:2*CW]);
                r_qx  <= sub_e(r_px, r_va[CW-1:0]);
                r_qy  <= sub_e(r_py, r_va[2*CW-1:CW]);
                r_qz  <= sub_e(r_pz, r_va[3*CW-1:2*CW]);
            end
            OP_DOT: begin
                r_dacc <= dsum;
                if (i_cmd.comp_sel == 2'd2) begin
                    case (i_cmd.dot_sel)
                        3'd0:    r_d00 <= dq;
                        3'd1:    r_d01 <= dq;
                        3'd2:    r_d11 <= dq;
                        3'd3:    r_d20 <= dq;
                        default: r_d21 <= dq;
                    endcase
                end
            end
            OP_MUL: begin
                r_macc <= msum;
                if (mp[0] && mhalf) begin
                    case (mp[2:1])
                        2'd0:    r_den <= msum;
                        2'd1:    r_vn  <= msum;
                        default: r_wn  <= msum;
                    endcase
                end
            end
            OP_DIV_INIT: begin
                r_rv <= r_vn;
                r_rw <= r_wn;
                r_fv <= '0;
                r_fw <= '0;
            end
            OP_DIV: begin
                r_rv <= gev ? PW'(rv2 - dden) : PW'(rv2);
                r_rw <= gew ? PW'(rw2 - dden) : PW'(rw2);
                r_fv <= {r_fv[FW-2:0], gev};
                r_fw <= {r_fw[FW-2:0], gew};
            end
            OP_H1: r_hacc <= SW'(hprod);
            OP_H2: r_hacc <= r_hacc + SW'(hprod);
            OP_H3: begin
                r_height <= hsat;
                r_found  <= 1'b1;
            end
            OP_TRI_INC: r_tri_idx <= r_tri_idx + 1'b1;
            OP_FINISH: begin
                r_out_z <= do_snap ? snap_sat : r_pz;
                r_out_h <= r_height;
                r_out_f <= r_found;
            end
            default: begin
                r_dacc <= r_dacc;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_cmd.op == OP_FINISH);
            if (i_cmd.op == OP_FINISH && do_snap) begin
                r_flag <= ~r_flag;
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_new_z          = r_out_z;
    assign o_terrain_height = r_out_h;
    assign o_triangle_found = r_out_f;
    assign o_above_flag     = r_flag;

endmodule

// ===== rtl/terrain_height_snap_hysteresis.sv =====
// Top level of the terrain height snap block: register port and glue.
// Depends on thsh_pkg, thsh_ctrl and thsh_datapath.
//
// Use:
//  - Input channel: an item is taken on a rising edge with start high and
//    busy low. Mode 0 writes a vertex, mode 1 a triangle (busy stays
//    low); mode 3 is dropped. Mode 2 runs a height query.
//  - A query scans triangles 0..n-1 in order (n = triangle_count, capped at
//    MAX_TRIANGLES) and stops at the first that holds the point.
//  - Per triangle the shared sequencer steps through store reads,
//    dot-product steps (one 17x17 product each), split 28x28 products
//    and one test; the hit adds restoring division and interpolation.
//  - Result transfer: o_result_valid is high for one cycle with new_z,
//    terrain_height, triangle_found and above_flag; the receiver cannot
//    hold it off. The next item is taken in the cycle the result shows.
//  - Config: APB writes at 4*index, reads return the stored value.
//  - Reset (synchronous, low): sequencer idle, flag clear, registers to
//    their defaults; vertex and triangle stores are not cleared.
module terrain_height_snap_hysteresis
    import thsh_pkg::*;
#(
    parameter int MAX_VERTICES  = 128,
    parameter int MAX_TRIANGLES = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item channel
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_mode,
    input  logic [7:0]           i_slot,
    input  logic signed [CW-1:0] i_coord_x,
    input  logic signed [CW-1:0] i_coord_y,
    input  logic signed [CW-1:0] i_coord_z,
    input  logic [6:0]           i_corner_a,
    input  logic [6:0]           i_corner_b,
    input  logic [6:0]           i_corner_c,
    // result channel
    output logic                 o_result_valid,
    output logic signed [CW-1:0] o_new_z,
    output logic signed [CW-1:0] o_terrain_height,
    output logic                 o_triangle_found,
    output logic                 o_above_flag,
    // register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [RW-1:0]        r_tri_count;
    logic signed [CW-1:0] r_snap_offset, r_lower_thr, r_upper_thr;
    logic                 cfg_wr, accept, query_go;
    t_reg                 reg_idx;
    t_cmd                 cmd;
    t_stat                stat;

    assign pready  = 1'b1;
    assign reg_idx = t_reg'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tri_count   <= RW'(0);
            r_snap_offset <= 16'sd3;
            r_lower_thr   <= 16'sd26;
            r_upper_thr   <= 16'sd51;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_TRI_COUNT:   r_tri_count   <= pwdata[RW-1:0];
                REG_SNAP_OFFSET: r_snap_offset <= pwdata[CW-1:0];
                REG_LOWER_THR:   r_lower_thr   <= pwdata[CW-1:0];
                REG_UPPER_THR:   r_upper_thr   <= pwdata[CW-1:0];
                default:         r_tri_count   <= r_tri_count;
            endcase
        end
    end

    // read back, signed registers sign-extended
    always_comb begin
        case (reg_idx)
            REG_TRI_COUNT:   prdata = 32'(r_tri_count);
            REG_SNAP_OFFSET: prdata = 32'(r_snap_offset);
            REG_LOWER_THR:   prdata = 32'(r_lower_thr);
            REG_UPPER_THR:   prdata = 32'(r_upper_thr);
            default:         prdata = 32'd0;
        endcase
    end

    // loads complete on the transfer itself; only queries start the sequencer
    assign accept   = start && !busy;
    assign query_go = accept && (i_mode == MODE_QUERY);

    thsh_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_query_go (query_go),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    thsh_datapath #(
        .MAX_VERTICES  (MAX_VERTICES),
        .MAX_TRIANGLES (MAX_TRIANGLES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_mode           (i_mode),
        .i_slot           (i_slot),
        .i_coord_x        (i_coord_x),
        .i_coord_y        (i_coord_y),
        .i_coord_z        (i_coord_z),
        .i_corner_a       (i_corner_a),
        .i_corner_b       (i_corner_b),
        .i_corner_c       (i_corner_c),
        .i_tri_count      (r_tri_count),
        .i_snap_offset    (r_snap_offset),
        .i_lower_thr      (r_lower_thr),
        .i_upper_thr      (r_upper_thr),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_valid          (o_result_valid),
        .o_new_z          (o_new_z),
        .o_terrain_height (o_terrain_height),
        .o_triangle_found (o_triangle_found),
        .o_above_flag     (o_above_flag)
    );

endmodule

// ===== tb/terrain_height_snap_hysteresis_tb.sv =====
// Self-checking testbench for terrain_height_snap_hysteresis: loads meshes, runs height
// queries and compares each result with an in-bench height/snap predictor.
// Depends on thsh_pkg and the RTL top level only.
`timescale 1ns / 100ps

module terrain_height_snap_hysteresis_tb;
    import thsh_pkg::*;

    localparam int NUM_VERTS = 128;
    localparam int NUM_TRIS  = 256;

    typedef struct {
        t_mode             mode;
        logic [7:0]        slot;
        logic signed [15:0] x, y, z;
        logic [6:0]        a, b, c;
    } mesh_cmd_t;

    typedef struct {
        logic signed [15:0] new_z;
        logic signed [15:0] height;
        logic               found;
        logic               flag;
    } height_result_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    // item channel
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_mode = '0;
    logic [7:0]         i_slot = '0;
    logic signed [15:0] i_coord_x = '0, i_coord_y = '0, i_coord_z = '0;
    logic [6:0]         i_corner_a = '0, i_corner_b = '0, i_corner_c = '0;

    // result channel
    logic               o_result_valid;
    logic signed [15:0] o_new_z, o_terrain_height;
    logic               o_triangle_found, o_above_flag;

    // register port
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    terrain_height_snap_hysteresis dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .start(start), .busy(busy),
        .i_mode(i_mode), .i_slot(i_slot),
        .i_coord_x(i_coord_x), .i_coord_y(i_coord_y), .i_coord_z(i_coord_z),
        .i_corner_a(i_corner_a), .i_corner_b(i_corner_b), .i_corner_c(i_corner_c),
        .o_result_valid(o_result_valid), .o_new_z(o_new_z),
        .o_terrain_height(o_terrain_height), .o_triangle_found(o_triangle_found),
        .o_above_flag(o_above_flag),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: its own mesh copy, flag and register copies.
    // Updated at the edge where an item transfer happens.
    // ------------------------------------------------------------------
    longint mesh_x [NUM_VERTS];
    longint mesh_y [NUM_VERTS];
    longint mesh_z [NUM_VERTS];
    int     tri_a [NUM_TRIS];
    int     tri_b [NUM_TRIS];
    int     tri_c [NUM_TRIS];
    bit     snap_flag = 1'b0;

    int     cfg_tri_count = 0;
    longint cfg_offset = 3;
    longint cfg_lower = 26;
    longint cfg_upper = 51;

    height_result_t height_expect_q[$];
    mesh_cmd_t      cmd_q[$];
    int             mismatches = 0;

    function automatic longint sat16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // Q.16 dot product truncated toward zero to Q.8
    function automatic longint dot_q8(input longint ax, ay, az, bx, by, bz);
        return (ax * bx + ay * by + az * bz) / 256;
    endfunction

    // floor(n * 2^16 / d) for 0 <= n < d
    function automatic longint bary_frac(input longint n, input longint d);
        longint r, q;
        r = n;
        q = 0;
        for (int i = 0; i < 16; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 1;
            end
        end
        return q;
    endfunction

    task automatic predict_mesh_cmd(input mesh_cmd_t c);
        longint px, py, pz, hgt, thr, nz;
        longint e1x, e1y, e1z, e2x, e2y, e2z, qx, qy, qz;
        longint d00, d01, d11, d20, d21, den, vn, wn;
        int     n, va, vb, vc;
        bit     hit;
        height_result_t r;
        case (c.mode)
            MODE_VERTEX: begin
                // slots above the vertex store are dropped
                if (c.slot < NUM_VERTS) begin
                    mesh_x[c.slot] = c.x;
                    mesh_y[c.slot] = c.y;
                    mesh_z[c.slot] = c.z;
                end
            end
            MODE_TRIANGLE: begin
                tri_a[c.slot] = c.a;
                tri_b[c.slot] = c.b;
                tri_c[c.slot] = c.c;
            end
            MODE_QUERY: begin
                px = c.x;
                py = c.y;
                pz = c.z;
                hgt = 0;
                hit = 1'b0;
                n = (cfg_tri_count > NUM_TRIS) ? NUM_TRIS : cfg_tri_count;
                for (int t = 0; t < n && !hit; t++) begin
                    va = tri_a[t];
                    vb = tri_b[t];
                    vc = tri_c[t];
                    e1x = mesh_x[vb] - mesh_x[va];
                    e1y = mesh_y[vb] - mesh_y[va];
                    e1z = mesh_z[vb] - mesh_z[va];
                    e2x = mesh_x[vc] - mesh_x[va];
                    e2y = mesh_y[vc] - mesh_y[va];
                    e2z = mesh_z[vc] - mesh_z[va];
                    qx = px - mesh_x[va];
                    qy = py - mesh_y[va];
                    qz = pz - mesh_z[va];
                    d00 = dot_q8(e1x, e1y, e1z, e1x, e1y, e1z);
                    d01 = dot_q8(e1x, e1y, e1z, e2x, e2y, e2z);
                    d11 = dot_q8(e2x, e2y, e2z, e2x, e2y, e2z);
                    d20 = dot_q8(qx, qy, qz, e1x, e1y, e1z);
                    d21 = dot_q8(qx, qy, qz, e2x, e2y, e2z);
                    den = d00 * d11 - d01 * d01;
                    // degenerate triangles are skipped
                    if (den > 0) begin
                        vn = d11 * d20 - d01 * d21;
                        wn = d00 * d21 - d01 * d20;
                        if (vn >= 0 && wn >= 0 && vn + wn < den) begin
                            hgt = sat16(mesh_y[va] + (bary_frac(vn, den) * e1y
                                        + bary_frac(wn, den) * e2y) / 65536);
                            hit = 1'b1;
                        end
                    end
                end
                thr = snap_flag ? cfg_lower : cfg_upper;
                nz = pz;
                if (pz < hgt + thr) begin
                    nz = sat16(hgt + cfg_offset);
                    snap_flag = !snap_flag;
                end
                r.new_z  = nz[15:0];
                r.height = hgt[15:0];
                r.found  = hit;
                r.flag   = snap_flag;
                height_expect_q.push_back(r);
            end
            default: ;  // mode 3 is dropped by the block
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver: pops pending commands, random gap after each one.
    // ------------------------------------------------------------------
    mesh_cmd_t cur_cmd;
    int        gap_left = 0;
    bit        no_gaps = 1'b0;

    always @(posedge i_clk) begin
        mesh_cmd_t nxt;
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left <= 0;
        end else if (!(start && busy)) begin
            if (start)
                predict_mesh_cmd(cur_cmd);   // transfer at this edge
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                start <= 1'b0;
            end else if (cmd_q.size() != 0) begin
                nxt = cmd_q.pop_front();
                cur_cmd    <= nxt;
                i_mode     <= nxt.mode;
                i_slot     <= nxt.slot;
                i_coord_x  <= nxt.x;
                i_coord_y  <= nxt.y;
                i_coord_z  <= nxt.z;
                i_corner_a <= nxt.a;
                i_corner_b <= nxt.b;
                i_corner_c <= nxt.c;
                start      <= 1'b1;
                gap_left   <= no_gaps ? 0 : $urandom_range(0, 17);
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: every strobed result against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        height_result_t e;
        if (i_rst_n && o_result_valid) begin
            if (height_expect_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: new_z=%0d height=%0d found=%0b flag=%0b",
                             o_new_z, o_terrain_height, o_triangle_found, o_above_flag);
            end else begin
                e = height_expect_q.pop_front();
                if (o_new_z !== e.new_z || o_terrain_height !== e.height ||
                    o_triangle_found !== e.found || o_above_flag !== e.flag) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp z=%0d h=%0d f=%0b fl=%0b got z=%0d h=%0d f=%0b fl=%0b",
                                 e.new_z, e.height, e.found, e.flag, o_new_z,
                                 o_terrain_height, o_triangle_found, o_above_flag);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus side: shadow of the mesh as it will be after the queue.
    // ------------------------------------------------------------------
    longint gen_x [NUM_VERTS];
    longint gen_y [NUM_VERTS];
    longint gen_z [NUM_VERTS];
    int     gen_ta [NUM_TRIS];
    int     gen_tb [NUM_TRIS];
    int     gen_tc [NUM_TRIS];
    bit     vert_written [NUM_VERTS];
    int     vert_list[$];
    int     tri_fill = 0;   // triangles 0..tri_fill-1 are written

    function automatic logic signed [15:0] rand_coord();
        if ($urandom_range(0, 7) == 0)
            return $urandom();
        return $signed($urandom_range(0, 16383)) - 16'sd8192;
    endfunction

    task automatic push_cmd(input t_mode m, input int slot, input longint x, y, z,
                            input int a, b, c);
        mesh_cmd_t cmd;
        cmd.mode = m;
        cmd.slot = slot;
        cmd.x = x[15:0];
        cmd.y = y[15:0];
        cmd.z = z[15:0];
        cmd.a = a;
        cmd.b = b;
        cmd.c = c;
        cmd_q.push_back(cmd);
    endtask

    task automatic add_vertex(input int slot, input longint x, y, z);
        push_cmd(MODE_VERTEX, slot, x, y, z, $urandom_range(0, 127),
                 $urandom_range(0, 127), $urandom_range(0, 127));
        if (slot < NUM_VERTS) begin
            gen_x[slot] = x;
            gen_y[slot] = y;
            gen_z[slot] = z;
            if (!vert_written[slot]) begin
                vert_written[slot] = 1'b1;
                vert_list.push_back(slot);
            end
        end
    endtask

    task automatic add_triangle(input int slot, input int a, b, c);
        push_cmd(MODE_TRIANGLE, slot, rand_coord(), rand_coord(), rand_coord(), a, b, c);
        gen_ta[slot] = a;
        gen_tb[slot] = b;
        gen_tc[slot] = c;
        if (slot == tri_fill)
            tri_fill++;
    endtask

    // random corners among written vertices, sometimes degenerate
    task automatic add_random_triangle();
        int slot, a, b, c;
        slot = (tri_fill < NUM_TRIS && ($urandom_range(0, 3) != 0 || tri_fill == 0))
               ? tri_fill : $urandom_range(0, tri_fill - 1);
        a = vert_list[$urandom_range(0, vert_list.size() - 1)];
        b = vert_list[$urandom_range(0, vert_list.size() - 1)];
        c = vert_list[$urandom_range(0, vert_list.size() - 1)];
        if ($urandom_range(0, 7) == 0)
            b = a;
        add_triangle(slot, a, b, c);
    endtask

    task automatic add_query(input longint x, y, z);
        push_cmd(MODE_QUERY, $urandom_range(0, 255), x, y, z, $urandom_range(0, 127),
                 $urandom_range(0, 127), $urandom_range(0, 127));
    endtask

    // point inside one of the scanned triangles, small jitter now and then
    task automatic add_surface_query();
        int k, s, t, va;
        longint p[3], e1[3], e2[3], base[3];
        if (cfg_tri_count == 0) begin
            add_query(rand_coord(), rand_coord(), rand_coord());
            return;
        end
        k = $urandom_range(0, ((cfg_tri_count > NUM_TRIS) ? NUM_TRIS : cfg_tri_count) - 1);
        s = $urandom_range(0, 255);
        t = $urandom_range(0, 255 - s);
        va = gen_ta[k];
        base = '{gen_x[va], gen_y[va], gen_z[va]};
        e1 = '{gen_x[gen_tb[k]] - base[0], gen_y[gen_tb[k]] - base[1],
               gen_z[gen_tb[k]] - base[2]};
        e2 = '{gen_x[gen_tc[k]] - base[0], gen_y[gen_tc[k]] - base[1],
               gen_z[gen_tc[k]] - base[2]};
        for (int i = 0; i < 3; i++) begin
            p[i] = sat16(base[i] + (s * e1[i] + t * e2[i]) / 256);
            if ($urandom_range(0, 3) == 0)
                p[i] = sat16(p[i] + $urandom_range(0, 64) - 32);
        end
        add_query(p[0], p[1], p[2]);
    endtask

    task automatic apb_write(input t_reg idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4 * idx;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);   // register written at this edge
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TRI_COUNT:   cfg_tri_count = val[8:0];
            REG_SNAP_OFFSET: cfg_offset = $signed(val[15:0]);
            REG_LOWER_THR:   cfg_lower = $signed(val[15:0]);
            REG_UPPER_THR:   cfg_upper = $signed(val[15:0]);
            default: ;
        endcase
    endtask

    task automatic set_thresholds(input logic [15:0] off, lo, hi);
        apb_write(REG_SNAP_OFFSET, {16'h0, off});
        apb_write(REG_LOWER_THR, {16'h0, lo});
        apb_write(REG_UPPER_THR, {16'h0, hi});
    endtask

    // all transfers done, nothing outstanding, then a short settle for
    // any trailing load still in the block
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (cmd_q.size() != 0 || start || busy || height_expect_q.size() != 0);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int r, lim;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // -------- directed: reset settings, no triangles scanned --------
        no_gaps = 1'b1;
        add_vertex(0, 0, 0, 0);
        add_vertex(1, 4096, 256, 0);
        add_vertex(2, 0, 512, 4096);
        add_vertex(127, 32767, -32768, 32767);
        add_vertex(64, -32768, 32767, -32768);
        add_vertex(200, 111, 222, 333);          // outside vertex store: dropped
        add_triangle(0, 0, 0, 1);                // degenerate
        add_triangle(1, 0, 1, 2);
        add_triangle(2, 127, 64, 0);             // extreme corners
        add_triangle(3, 2, 1, 0);
        push_cmd(MODE_NONE, 255, -1, -1, -1, 127, 127, 127);
        add_query(0, 0, -32768);
        add_query(32767, 32767, 32767);
        add_query(-32768, -32768, 0);
        wait_idle();

        // -------- directed: small mesh, extreme registers --------
        apb_write(REG_TRI_COUNT, 4);
        set_thresholds(16'h7fff, 16'h8000, 16'h7fff);
        add_query(1024, 192, 1024);
        add_query(1024, 192, 1024);
        add_query(3000, 100, 500);
        add_query(-32768, 32767, -32768);
        wait_idle();
        set_thresholds(16'h8000, 16'h7fff, 16'h8000);
        add_query(1024, 192, 1024);
        add_query(100, 50, 100);
        add_query(32767, -32768, 32767);
        wait_idle();

        // -------- random phases --------
        for (int ph = 0; ph < 6; ph++) begin
            lim = (tri_fill > 48) ? 48 : tri_fill;
            case (ph % 3)
                0: apb_write(REG_TRI_COUNT, tri_fill);
                1: apb_write(REG_TRI_COUNT, $urandom_range(0, lim));
                default: apb_write(REG_TRI_COUNT, lim);
            endcase
            if (ph == 2)
                set_thresholds(16'h0000, 16'h0000, 16'h0000);
            else
                set_thresholds($urandom_range(0, 1023) - 512, $urandom_range(0, 2047) - 1024,
                               $urandom_range(0, 4095) - 1024);
            no_gaps = (ph == 3);
            repeat (22) begin
                r = $urandom_range(0, 99);
                if (r < 15)
                    add_vertex($urandom_range(0, 9) == 0 ? $urandom_range(128, 255)
                               : $urandom_range(0, 127), rand_coord(), rand_coord(),
                               rand_coord());
                else if (r < 45)
                    add_random_triangle();
                else if (r < 50)
                    push_cmd(MODE_NONE, $urandom_range(0, 255), rand_coord(), rand_coord(),
                             rand_coord(), $urandom_range(0, 127), $urandom_range(0, 127),
                             $urandom_range(0, 127));
                else if (r < 88)
                    add_surface_query();
                else
                    add_query(rand_coord(), rand_coord(), rand_coord());
            end
            wait_idle();
        end

        // -------- full store, then counts beyond the store size --------
        no_gaps = 1'b0;
        while (tri_fill < NUM_TRIS)
            add_random_triangle();
        wait_idle();
        apb_write(REG_TRI_COUNT, NUM_TRIS);
        set_thresholds($urandom(), $urandom(), $urandom());
        add_surface_query();
        add_surface_query();
        add_query(rand_coord(), rand_coord(), rand_coord());
        wait_idle();
        apb_write(REG_TRI_COUNT, 9'h1ff);
        add_surface_query();
        add_surface_query();
        add_query(32767, 32767, 32767);
        wait_idle();

        if (mismatches == 0 && height_expect_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
